[rtl/dpbp_pkg.sv]
// Package for the disparity back-projection pipeline.
// Field widths, register indexes and the carried pipeline records.
// No dependencies.
package dpbp_pkg;

    localparam int COORD_BITS_DEF = 12;

    localparam int DISP_W  = 8;
    localparam int COORD_W = 12;
    localparam int COLOR_W = 8;
    localparam int CFG_W   = 32;
    localparam int BFP_W   = 32;
    localparam int OFF_W   = 16;
    localparam int FOC_W   = 24;
    localparam int CTR_W   = 24;
    localparam int DEPTH_W = 32;
    localparam int TOL_W   = 16;
    localparam int POS_W   = 40;

    localparam int FRAC_W  = 8;
    localparam int DSH_W   = 6;
    localparam int DEN_W   = 17;
    localparam int NUM_W   = BFP_W + DSH_W;
    localparam int MAG_W   = 24;
    localparam int PROD_W  = MAG_W + DEPTH_W;

    localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    typedef enum logic [2:0] {
        REG_BFP,
        REG_DISP_OFF,
        REG_FOCAL_X,
        REG_FOCAL_Y,
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_MAX_DEPTH,
        REG_DEPTH_TOL
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_pix;

    typedef struct packed {
        logic               inv;
        logic               neg_x;
        logic               zero_x;
        logic               neg_y;
        logic               zero_y;
        logic [DEPTH_W-1:0] depth;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_tail;

endpackage

[rtl/dpbp_pix_if.sv]
// Input pixel channel: valid/ready handshake and pixel payload.
// Depends on dpbp_pkg.
interface dpbp_pix_if import dpbp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DISP_W-1:0]  disparity;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COLOR_W-1:0] blue_in;
    logic [COLOR_W-1:0] green_in;
    logic [COLOR_W-1:0] red_in;

    modport source (output valid, disparity, col, row, blue_in, green_in, red_in,
                    input ready);
    modport sink (input valid, disparity, col, row, blue_in, green_in, red_in,
                  output ready);
endinterface

[rtl/dpbp_pt_if.sv]
// Output point channel: valid/ready handshake and point payload.
// Depends on dpbp_pkg.
interface dpbp_pt_if import dpbp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               point_valid;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [DEPTH_W-1:0] pos_z;
    logic [COLOR_W-1:0] red_out;
    logic [COLOR_W-1:0] green_out;
    logic [COLOR_W-1:0] blue_out;

    modport source (output valid, point_valid, pos_x, pos_y, pos_z, red_out, green_out,
                    blue_out, input ready);
    modport sink (input valid, point_valid, pos_x, pos_y, pos_z, red_out, green_out,
                  blue_out, output ready);
endinterface

[rtl/disparity_to_point_back_projection.sv]
// Top level: disparity pixel to camera-space point, fully pipelined.
// Depends on dpbp_pkg, dpbp_pix_if, dpbp_pt_if.
//
// One pixel is taken per clock and one point leaves per clock while the
// pipeline advances. The stages are: one entry stage, 38 one-bit restoring
// divide stages for depth, a check/center stage, a multiply stage, 56 one-bit
// divide stages for X and Y in parallel, and the output register. The whole
// pipeline advances together; it holds only while the output register is full
// and the sink is not ready. Config registers are read live and must only be
// written while the pipeline is empty.
module disparity_to_point_back_projection import dpbp_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    dpbp_pix_if.sink              i_pix,
    dpbp_pt_if.source             o_pt
);

    localparam int N1 = NUM_W;
    localparam int N2 = PROD_W;
    localparam logic [COORD_W-1:0] CMASK = COORD_W'((64'd1 << COORD_BITS) - 64'd1);

    logic [BFP_W-1:0]   r_bfp;
    logic [OFF_W-1:0]   r_off;
    logic [FOC_W-1:0]   r_fx;
    logic [FOC_W-1:0]   r_fy;
    logic [CTR_W-1:0]   r_cx;
    logic [CTR_W-1:0]   r_cy;
    logic [DEPTH_W-1:0] r_maxd;
    logic [TOL_W-1:0]   r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bfp  <= '0;
            r_off  <= '0;
            r_fx   <= FOC_W'(256);
            r_fy   <= FOC_W'(256);
            r_cx   <= '0;
            r_cy   <= '0;
            r_maxd <= '1;
            r_tol  <= TOL_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_BFP:       r_bfp  <= i_cfg_data[BFP_W-1:0];
                REG_DISP_OFF:  r_off  <= i_cfg_data[OFF_W-1:0];
                REG_FOCAL_X:   r_fx   <= i_cfg_data[FOC_W-1:0];
                REG_FOCAL_Y:   r_fy   <= i_cfg_data[FOC_W-1:0];
                REG_CENTER_X:  r_cx   <= i_cfg_data[CTR_W-1:0];
                REG_CENTER_Y:  r_cy   <= i_cfg_data[CTR_W-1:0];
                REG_MAX_DEPTH: r_maxd <= i_cfg_data[DEPTH_W-1:0];
                REG_DEPTH_TOL: r_tol  <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_ov;

    assign w_en        = !r_ov || o_pt.ready;
    assign i_pix.ready = w_en;

    // depth divider: rem, numerator/quotient shifter, divisor
    logic               r_d1_v   [N1+1];
    logic [DEN_W-1:0]   r_d1_rem [N1+1];
    logic [NUM_W-1:0]   r_d1_nq  [N1+1];
    logic [DEN_W-1:0]   r_d1_den [N1+1];
    t_pix               r_d1_pix [N1+1];
    logic [DEN_W-1:0]   n_d1_rem [N1];
    logic [NUM_W-1:0]   n_d1_nq  [N1];

    always_comb begin
        logic [DEN_W:0] t;
        logic           ge;
        for (int k = 0; k < N1; k++) begin
            t  = {r_d1_rem[k], r_d1_nq[k][NUM_W-1]};
            ge = t >= {1'b0, r_d1_den[k]};
            n_d1_rem[k] = ge ? DEN_W'(t - {1'b0, r_d1_den[k]}) : t[DEN_W-1:0];
            n_d1_nq[k]  = {r_d1_nq[k][NUM_W-2:0], ge};
        end
    end

    // check / center stage
    logic               r_p_v;
    logic               r_p_inv;
    logic [DEPTH_W-1:0] r_p_depth;
    logic               r_p_negx, r_p_negy;
    logic [MAG_W-1:0]   r_p_magx, r_p_magy;
    t_pix               r_p_pix;

    logic [DEPTH_W-1:0] n_depth;
    logic [DEPTH_W-1:0] n_diff;
    logic [CTR_W-1:0]   n_cx, n_cy;

    assign n_depth = (|r_d1_nq[N1][NUM_W-1:DEPTH_W]) ? '1 : r_d1_nq[N1][DEPTH_W-1:0];
    assign n_diff  = (n_depth > r_maxd) ? n_depth - r_maxd : r_maxd - n_depth;
    assign n_cx    = CTR_W'({r_d1_pix[N1].col, {FRAC_W{1'b0}}});
    assign n_cy    = CTR_W'({r_d1_pix[N1].row, {FRAC_W{1'b0}}});

    // X/Y divider; index 0 is the multiply stage
    logic               r_d2_v    [N2+1];
    logic [FOC_W-1:0]   r_d2_remx [N2+1];
    logic [FOC_W-1:0]   r_d2_remy [N2+1];
    logic [PROD_W-1:0]  r_d2_nqx  [N2+1];
    logic [PROD_W-1:0]  r_d2_nqy  [N2+1];
    t_tail              r_d2_tail [N2+1];
    logic [FOC_W-1:0]   n_d2_remx [N2];
    logic [FOC_W-1:0]   n_d2_remy [N2];
    logic [PROD_W-1:0]  n_d2_nqx  [N2];
    logic [PROD_W-1:0]  n_d2_nqy  [N2];

    always_comb begin
        logic [FOC_W:0] tx, ty;
        logic           gx, gy;
        for (int k = 0; k < N2; k++) begin
            tx = {r_d2_remx[k], r_d2_nqx[k][PROD_W-1]};
            ty = {r_d2_remy[k], r_d2_nqy[k][PROD_W-1]};
            gx = tx >= {1'b0, r_fx};
            gy = ty >= {1'b0, r_fy};
            n_d2_remx[k] = gx ? FOC_W'(tx - {1'b0, r_fx}) : tx[FOC_W-1:0];
            n_d2_remy[k] = gy ? FOC_W'(ty - {1'b0, r_fy}) : ty[FOC_W-1:0];
            n_d2_nqx[k]  = {r_d2_nqx[k][PROD_W-2:0], gx};
            n_d2_nqy[k]  = {r_d2_nqy[k][PROD_W-2:0], gy};
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= N1; k++) r_d1_v[k] <= 1'b0;
            for (int k = 0; k <= N2; k++) r_d2_v[k] <= 1'b0;
            r_p_v <= 1'b0;
            r_ov  <= 1'b0;
        end else if (w_en) begin
            r_d1_v[0] <= i_pix.valid;
            for (int k = 0; k < N1; k++) r_d1_v[k+1] <= r_d1_v[k];
            r_p_v     <= r_d1_v[N1];
            r_d2_v[0] <= r_p_v;
            for (int k = 0; k < N2; k++) r_d2_v[k+1] <= r_d2_v[k];
            r_ov      <= r_d2_v[N2];
        end
    end

    // payload
    logic [PROD_W-1:0] w_qx, w_qy;
    logic [POS_W-1:0]  n_px, n_py;
    t_tail             w_tl;

    assign w_qx = r_d2_nqx[N2];
    assign w_qy = r_d2_nqy[N2];
    assign w_tl = r_d2_tail[N2];

    always_comb begin
        logic [POS_W-1:0] sx, sy;
        if (w_tl.neg_x) sx = (w_qx > PROD_W'(POS_MIN)) ? POS_MIN : w_qx[POS_W-1:0];
        else            sx = (w_qx > PROD_W'(POS_MAX)) ? POS_MAX : w_qx[POS_W-1:0];
        if (w_tl.neg_y) sy = (w_qy > PROD_W'(POS_MIN)) ? POS_MIN : w_qy[POS_W-1:0];
        else            sy = (w_qy > PROD_W'(POS_MAX)) ? POS_MAX : w_qy[POS_W-1:0];
        n_px = (w_tl.inv || w_tl.zero_x) ? '0 : (w_tl.neg_x ? POS_W'(0) - sx : sx);
        n_py = (w_tl.inv || w_tl.zero_y) ? '0 : (w_tl.neg_y ? POS_W'(0) - sy : sy);
    end

    logic               r_o_pv;
    logic [POS_W-1:0]   r_o_px, r_o_py;
    logic [DEPTH_W-1:0] r_o_pz;
    logic [COLOR_W-1:0] r_o_r, r_o_g, r_o_b;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d1_rem[0]     <= '0;
            r_d1_nq[0]      <= {r_bfp, {DSH_W{1'b0}}};
            r_d1_den[0]     <= DEN_W'({i_pix.disparity, {DSH_W{1'b0}}}) + DEN_W'(r_off);
            r_d1_pix[0].col   <= i_pix.col & CMASK;
            r_d1_pix[0].row   <= i_pix.row & CMASK;
            r_d1_pix[0].red   <= i_pix.red_in;
            r_d1_pix[0].green <= i_pix.green_in;
            r_d1_pix[0].blue  <= i_pix.blue_in;
            for (int k = 0; k < N1; k++) begin
                r_d1_rem[k+1] <= n_d1_rem[k];
                r_d1_nq[k+1]  <= n_d1_nq[k];
                r_d1_den[k+1] <= r_d1_den[k];
                r_d1_pix[k+1] <= r_d1_pix[k];
            end

            r_p_depth <= n_depth;
            r_p_inv   <= n_diff < DEPTH_W'(r_tol);
            r_p_negx  <= r_cx > n_cx;
            r_p_negy  <= r_cy > n_cy;
            r_p_magx  <= (r_cx > n_cx) ? r_cx - n_cx : n_cx - r_cx;
            r_p_magy  <= (r_cy > n_cy) ? r_cy - n_cy : n_cy - r_cy;
            r_p_pix   <= r_d1_pix[N1];

            r_d2_remx[0]         <= '0;
            r_d2_remy[0]         <= '0;
            r_d2_nqx[0]          <= PROD_W'(r_p_magx) * PROD_W'(r_p_depth);
            r_d2_nqy[0]          <= PROD_W'(r_p_magy) * PROD_W'(r_p_depth);
            r_d2_tail[0].inv     <= r_p_inv;
            r_d2_tail[0].neg_x   <= r_p_negx;
            r_d2_tail[0].neg_y   <= r_p_negy;
            r_d2_tail[0].zero_x  <= (r_p_magx == '0) || (r_p_depth == '0);
            r_d2_tail[0].zero_y  <= (r_p_magy == '0) || (r_p_depth == '0);
            r_d2_tail[0].depth   <= r_p_depth;
            r_d2_tail[0].red     <= r_p_pix.red;
            r_d2_tail[0].green   <= r_p_pix.green;
            r_d2_tail[0].blue    <= r_p_pix.blue;
            for (int k = 0; k < N2; k++) begin
                r_d2_remx[k+1] <= n_d2_remx[k];
                r_d2_remy[k+1] <= n_d2_remy[k];
                r_d2_nqx[k+1]  <= n_d2_nqx[k];
                r_d2_nqy[k+1]  <= n_d2_nqy[k];
                r_d2_tail[k+1] <= r_d2_tail[k];
            end

            r_o_pv <= !w_tl.inv;
            r_o_px <= n_px;
            r_o_py <= n_py;
            r_o_pz <= w_tl.inv ? '0 : w_tl.depth;
            r_o_r  <= w_tl.inv ? '0 : w_tl.red;
            r_o_g  <= w_tl.inv ? '0 : w_tl.green;
            r_o_b  <= w_tl.inv ? '0 : w_tl.blue;
        end
    end

    assign o_pt.valid       = r_ov;
    assign o_pt.point_valid = r_o_pv;
    assign o_pt.pos_x       = r_o_px;
    assign o_pt.pos_y       = r_o_py;
    assign o_pt.pos_z       = r_o_pz;
    assign o_pt.red_out     = r_o_r;
    assign o_pt.green_out   = r_o_g;
    assign o_pt.blue_out    = r_o_b;

endmodule

[rtl/dpbp_chk.sv]
// Port-level checker for the back-projection top level, bound in below.
// Depends on dpbp_pkg.
module dpbp_chk import dpbp_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_point_valid,
    input logic [POS_W-1:0]   i_pos_x,
    input logic [POS_W-1:0]   i_pos_y,
    input logic [DEPTH_W-1:0] i_pos_z,
    input logic [COLOR_W-1:0] i_red,
    input logic [COLOR_W-1:0] i_green,
    input logic [COLOR_W-1:0] i_blue
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pos_x))
        else $error("output transfer dropped while stalled");

    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_point_valid |-> i_pos_x == '0 && i_pos_y == '0 &&
        i_pos_z == '0 && i_red == '0 && i_green == '0 && i_blue == '0)
        else $error("invalid point carries nonzero data");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without output backpressure");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind disparity_to_point_back_projection dpbp_chk u_dpbp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_pix.ready),
    .i_out_valid   (o_pt.valid),
    .i_out_ready   (o_pt.ready),
    .i_point_valid (o_pt.point_valid),
    .i_pos_x       (o_pt.pos_x),
    .i_pos_y       (o_pt.pos_y),
    .i_pos_z       (o_pt.pos_z),
    .i_red         (o_pt.red_out),
    .i_green       (o_pt.green_out),
    .i_blue        (o_pt.blue_out)
);

[dv/testbench.sv]
// Self-checking testbench for disparity_to_point_back_projection.
// Drives pixels through dpbp_pix_if and checks each point against an in-file predictor
// over several register settings. Depends on dpbp_pkg, dpbp_pix_if and dpbp_pt_if.
module testbench;
    import dpbp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  NUM_PHASES  = 6;
    localparam int  RAND_ITEMS  = 1300;
    localparam int  DRAIN_WAIT  = 120;
    localparam int  HOLD_CYCLES = 400;
    localparam longint LIMIT    = 600000;

    typedef struct {
        logic [DISP_W-1:0]  disp;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } t_pixel;

    typedef struct {
        logic               ok;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [DEPTH_W-1:0] z;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_point;

    typedef struct {
        t_pixel px;
        logic   typed;
        t_point pt;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    dpbp_pix_if pix ();
    dpbp_pt_if  pt ();

    disparity_to_point_back_projection i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_pix     (pix.sink),
        .o_pt      (pt.source)
    );

    // register shadow
    logic [BFP_W-1:0]   bfp;
    logic [OFF_W-1:0]   disp_off;
    logic [FOC_W-1:0]   fx, fy;
    logic [CTR_W-1:0]   cx, cy;
    logic [DEPTH_W-1:0] max_dep;
    logic [TOL_W-1:0]   tol;

    t_point expected_points[$];
    int     errors = 0;
    int     reported = 0;
    int     sent = 0;
    longint cycles = 0;
    bit     tx_calm = 0;
    bit     rx_calm = 0;
    bit     hold_req = 0;
    bit     hold_done = 0;
    int     hold_cnt = 0;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        rx_calm <= (cycles > 1500 && cycles < 3000);
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [DEPTH_W-1:0] depth_of(logic [DISP_W-1:0] d);
        logic [63:0] den, q;
        den = ({56'd0, d} << DSH_W) + disp_off;
        if (den == 0) return '1;
        q = ({32'd0, bfp} << DSH_W) / den;
        return (q > 64'hFFFF_FFFF) ? '1 : q[31:0];
    endfunction

    function automatic logic [POS_W-1:0] axis_proj(logic [COORD_W-1:0] coord,
                                                    logic [CTR_W-1:0] ctr,
                                                    logic [FOC_W-1:0] foc,
                                                    logic [DEPTH_W-1:0] dep);
        logic [63:0] c, mag, prod, q, lim;
        logic neg;
        c = {52'd0, coord} << FRAC_W;
        neg = ctr > c;
        mag = neg ? (ctr - c) : (c - ctr);
        prod = mag * dep;
        lim = neg ? 64'h80_0000_0000 : 64'h7F_FFFF_FFFF;
        if (prod == 0) return '0;
        if (foc == 0) q = lim;
        else begin
            q = prod / foc;
            if (q > lim) q = lim;
        end
        if (neg) q = -q;
        return q[POS_W-1:0];
    endfunction

    function automatic t_point predict_point(t_pixel px);
        t_point r;
        logic [DEPTH_W-1:0] dep;
        logic [DEPTH_W-1:0] diff;
        dep = depth_of(px.disp);
        diff = (dep > max_dep) ? dep - max_dep : max_dep - dep;
        r = '{default: '0};
        if (diff < tol) return r;
        r.ok = 1'b1;
        r.x = axis_proj(px.col, cx, fx, dep);
        r.y = axis_proj(px.row, cy, fy, dep);
        r.z = dep;
        r.red = px.red;
        r.green = px.green;
        r.blue = px.blue;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pt.ready <= 1'b0;
        end else begin
            if (pt.valid && pt.ready) begin
                if (expected_points.size() == 0) begin
                    errors++;
                    if (reported < 10) begin
                        reported++;
                        $display("unexpected point transfer at cycle %0d", cycles);
                    end
                end else begin
                    t_point e;
                    e = expected_points.pop_front();
                    if (pt.point_valid !== e.ok || pt.pos_x !== e.x || pt.pos_y !== e.y ||
                        pt.pos_z !== e.z || pt.red_out !== e.red ||
                        pt.green_out !== e.green || pt.blue_out !== e.blue) begin
                        errors++;
                        if (reported < 10) begin
                            reported++;
                            $display("point mismatch: exp v=%0b x=%h y=%h z=%h rgb=%h %h %h",
                                     e.ok, e.x, e.y, e.z, e.red, e.green, e.blue);
                            $display("                got v=%0b x=%h y=%h z=%h rgb=%h %h %h",
                                     pt.point_valid, pt.pos_x, pt.pos_y, pt.pos_z,
                                     pt.red_out, pt.green_out, pt.blue_out);
                        end
                    end
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                pt.ready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_done <= 1'b1;
                hold_cnt <= HOLD_CYCLES;
                pt.ready <= 1'b0;
            end else begin
                pt.ready <= rx_calm || ($urandom_range(99) >= 21);
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        unique case (idx)
            REG_BFP:       bfp = val;
            REG_DISP_OFF:  disp_off = val[OFF_W-1:0];
            REG_FOCAL_X:   fx = val[FOC_W-1:0];
            REG_FOCAL_Y:   fy = val[FOC_W-1:0];
            REG_CENTER_X:  cx = val[CTR_W-1:0];
            REG_CENTER_Y:  cy = val[CTR_W-1:0];
            REG_MAX_DEPTH: max_dep = val;
            REG_DEPTH_TOL: tol = val[TOL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_pixel(t_pixel px, bit typed, t_point typed_pt);
        while (!tx_calm && $urandom_range(99) < 21) begin
            pix.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.disparity <= px.disp;
        pix.col <= px.col;
        pix.row <= px.row;
        pix.blue_in <= px.blue;
        pix.green_in <= px.green;
        pix.red_in <= px.red;
        do @(posedge i_clk); while (!pix.ready);
        expected_points.push_back(typed ? typed_pt : predict_point(px));
        sent++;
        tx_calm = (sent >= 300 && sent < 500);
        if (sent == 700) hold_req = 1;
    endtask

    task automatic drain();
        pix.valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic t_pixel rand_pixel();
        t_pixel px;
        case ($urandom_range(9))
            0: px.disp = '0;
            1: px.disp = 8'hFF;
            default: px.disp = DISP_W'($urandom_range(255));
        endcase
        px.col = COORD_W'($urandom_range(4095));
        px.row = COORD_W'($urandom_range(4095));
        px.blue = COLOR_W'($urandom_range(255));
        px.green = COLOR_W'($urandom_range(255));
        px.red = COLOR_W'($urandom_range(255));
        return px;
    endfunction

    task automatic set_phase(int p);
        logic [DEPTH_W-1:0] d;
        case (p)
            0: begin
                write_reg(REG_BFP, '1);
                write_reg(REG_DISP_OFF, 32'hFFFF);
                write_reg(REG_FOCAL_X, 32'd1);
                write_reg(REG_FOCAL_Y, 32'hFF_FFFF);
                write_reg(REG_CENTER_X, 32'hFF_FFFF);
                write_reg(REG_CENTER_Y, 32'd0);
                write_reg(REG_MAX_DEPTH, 32'd0);
                write_reg(REG_DEPTH_TOL, 32'hFFFF);
            end
            1: begin
                write_reg(REG_BFP, '1);
                write_reg(REG_DISP_OFF, 32'd0);
                write_reg(REG_FOCAL_X, 32'hFF_FFFF);
                write_reg(REG_FOCAL_Y, 32'd1);
                write_reg(REG_CENTER_X, 32'd0);
                write_reg(REG_CENTER_Y, 32'hFF_FFFF);
                write_reg(REG_MAX_DEPTH, '1);
                write_reg(REG_DEPTH_TOL, 32'd0);
            end
            default: begin
                write_reg(REG_BFP, $urandom());
                write_reg(REG_DISP_OFF, $urandom_range(p[0] ? 255 : 65535));
                write_reg(REG_FOCAL_X, $urandom_range(1, p == 2 ? 16777215 : 65535));
                write_reg(REG_FOCAL_Y, $urandom_range(1, p == 3 ? 16777215 : 65535));
                write_reg(REG_CENTER_X, $urandom_range(p == 4 ? 16777215 : 1048575));
                write_reg(REG_CENTER_Y, $urandom_range(p == 5 ? 16777215 : 1048575));
                write_reg(REG_DEPTH_TOL, $urandom_range(1, p == 3 ? 65535 : 300));
                // put the unknown-depth marker near a reachable depth
                d = depth_of(DISP_W'($urandom_range(255))) + DEPTH_W'($urandom_range(100));
                write_reg(REG_MAX_DEPTH, d);
            end
        endcase
    endtask

    t_row directed[] = '{
        '{'{8'd0, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00}, 1'b1,
          '{1'b0, '0, '0, '0, 8'h00, 8'h00, 8'h00}},
        '{'{8'd0, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
          '{1'b0, '0, '0, '0, 8'h00, 8'h00, 8'h00}},
        '{'{8'hFF, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
          '{1'b1, '0, '0, '0, 8'hFF, 8'hFF, 8'hFF}},
        '{'{8'd1, 12'd0, 12'd0, 8'h12, 8'h34, 8'h56}, 1'b1,
          '{1'b1, '0, '0, '0, 8'h56, 8'h34, 8'h12}},
        '{'{8'h80, 12'hAAA, 12'h555, 8'hA5, 8'h5A, 8'h0F}, 1'b1,
          '{1'b1, '0, '0, '0, 8'h0F, 8'h5A, 8'hA5}},
        '{'{8'h7F, 12'h555, 12'hAAA, 8'h5A, 8'hA5, 8'hF0}, 1'b0, '{default: '0}},
        '{'{8'd1, 12'hFFF, 12'd0, 8'h01, 8'h02, 8'h03}, 1'b0, '{default: '0}},
        '{'{8'hFF, 12'd0, 12'hFFF, 8'h80, 8'h40, 8'h20}, 1'b0, '{default: '0}},
        '{'{8'd0, 12'h800, 12'h7FF, 8'h11, 8'h22, 8'h33}, 1'b0, '{default: '0}},
        '{'{8'd2, 12'd1, 12'd1, 8'hFE, 8'hFD, 8'hFC}, 1'b0, '{default: '0}}
    };

    initial begin
        t_point none;
        none = '{default: '0};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        pix.valid = 1'b0;
        pix.disparity = '0;
        pix.col = '0;
        pix.row = '0;
        pix.blue_in = '0;
        pix.green_in = '0;
        pix.red_in = '0;
        bfp = '0;
        disp_off = '0;
        fx = 24'd256;
        fy = 24'd256;
        cx = '0;
        cy = '0;
        max_dep = '1;
        tol = 16'd1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // typed rows hold for reset registers; the rest go through the predictor
        foreach (directed[i]) send_pixel(directed[i].px, directed[i].typed, directed[i].pt);
        drain();
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_phase(p);
            if (p < 2)
                foreach (directed[i]) send_pixel(directed[i].px, 1'b0, none);
            for (int n = 0; n < RAND_ITEMS / NUM_PHASES; n++)
                send_pixel(rand_pixel(), 1'b0, none);
            drain();
        end

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/dpbp_pkg.sv
rtl/dpbp_pix_if.sv
rtl/dpbp_pt_if.sv
rtl/disparity_to_point_back_projection.sv
rtl/dpbp_chk.sv
dv/testbench.sv
